FILE: design/fsl_pkg.sv
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared constants and types for the floor-sum block: data width, default
// operand width and the command word of the shared multiply/divide unit.
// ----------------------------------------------------------------------------
package fsl_pkg;

   // Width of slope, offset, products, quotients and the running total
   localparam int DATA_BITS = 64;

   // Default width of term count and modulus actually used
   localparam int OPERAND_BITS_DEF = 32;

   // Command to the shared arithmetic unit
   typedef struct packed {
      logic start;    // load operands and begin an operation
      logic is_div;   // 1: divide x by y, 0: multiply x by y (mod 2^64)
   } alu_cmd_type;

endpackage

FILE: design/fsl_alu.sv
// ----------------------------------------------------------------------------
// fsl_alu
// Shared bit-serial arithmetic unit: 64-bit shift-add multiply (low 64 bits
// of the product) or 64-bit by OPERAND_BITS restoring division, one bit per
// cycle. done pulses for one cycle; results hold until the next start.
// ----------------------------------------------------------------------------
module fsl_alu #(
   parameter int OPERAND_BITS = fsl_pkg::OPERAND_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fsl_pkg::alu_cmd_type      cmd,
   input  logic [63:0]               opnd_x,
   input  logic [63:0]               opnd_y,
   output logic                      done,
   output logic [63:0]               result,
   output logic [OPERAND_BITS-1:0]   remainder
);

   localparam int DW = fsl_pkg::DATA_BITS;
   localparam int CW = $clog2(DW);

   logic                    busy_ff, busy_in;
   logic                    div_ff, div_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [DW-1:0]           acc_ff, acc_in;
   logic [DW-1:0]           x_ff, x_in;
   logic [DW-1:0]           y_ff, y_in;
   logic [OPERAND_BITS-1:0] rem_ff, rem_in;

   logic [OPERAND_BITS:0]   rem_shift;
   logic [OPERAND_BITS:0]   rem_diff;
   logic                    q_bit;
   logic                    last;

   // one step of the current operation
   always_comb begin
      rem_shift = {rem_ff, x_ff[DW-1]};
      rem_diff  = rem_shift - {1'b0, y_ff[OPERAND_BITS-1:0]};
      q_bit     = (rem_shift >= {1'b0, y_ff[OPERAND_BITS-1:0]});
      last      = 1'b0;

      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      rem_in  = rem_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         cnt_in  = '1;
         acc_in  = '0;
         x_in    = opnd_x;
         y_in    = opnd_y;
         rem_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         x_in   = {x_ff[DW-2:0], 1'b0};
         if (div_ff) begin
            // restoring division: quotient bits shift into acc
            acc_in = {acc_ff[DW-2:0], q_bit};
            rem_in = q_bit ? rem_diff[OPERAND_BITS-1:0]
                           : rem_shift[OPERAND_BITS-1:0];
            last   = (cnt_ff == '0);
         end else begin
            // shift-add multiply, stops once no multiplier bits remain
            if (y_ff[0]) begin
               acc_in = acc_ff + x_ff;
            end
            y_in = {1'b0, y_ff[DW-1:1]};
            last = (cnt_ff == '0) || (y_ff[DW-1:1] == '0);
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign result    = acc_ff;
   assign remainder = rem_ff;

endmodule

FILE: design/floor_sum_linear_top.sv
// ----------------------------------------------------------------------------
// floor_sum_linear_top
// Sum over i = 0..n-1 of floor((a*i + b) / m), modulo 2^64, by a Euclid-like
// reduction sequenced over one shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    term_count, modulus, slope, offset
//  rsp_      out        rsp_valid/rsp_ready    floor_total
//
//  A multiply ends once the multiplier has no set bits left; a division runs
//  over every dividend bit. A round issues up to seven operations, and the number
//  of rounds is bounded by the Euclid steps on (m, a). Zero modulus finishes at
//  once.
//  Reset clears the sequencer and the valid flags; there is nothing to sweep.
//  rsp_ready held low keeps the result; the next request is still taken and
//  run, and its result waits in the final state until the output register frees.
// ----------------------------------------------------------------------------
module floor_sum_linear_top #(
   parameter int OPERAND_BITS = fsl_pkg::OPERAND_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_term_count,
   input  logic [31:0]        req_modulus,
   input  logic signed [63:0] req_slope,
   input  logic signed [63:0] req_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_floor_total
);

   localparam int DW = fsl_pkg::DATA_BITS;
   localparam int W  = OPERAND_BITS;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_A_CHECK   = 4'd1;
   localparam logic [3:0] ST_A_DIV     = 4'd2;
   localparam logic [3:0] ST_A_TRI     = 4'd3;
   localparam logic [3:0] ST_A_SCALE   = 4'd4;
   localparam logic [3:0] ST_B_CHECK   = 4'd5;
   localparam logic [3:0] ST_B_DIV     = 4'd6;
   localparam logic [3:0] ST_B_SCALE   = 4'd7;
   localparam logic [3:0] ST_TOP_MUL   = 4'd8;
   localparam logic [3:0] ST_TOP_CHECK = 4'd9;
   localparam logic [3:0] ST_TOP_DIV   = 4'd10;
   localparam logic [3:0] ST_FINISH    = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic          issued_ff, issued_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] total_ff, total_in;
   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  m_ff, m_in;
   logic [DW-1:0] a_ff, a_in;
   logic [DW-1:0] b_ff, b_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [DW-1:0] tmp_ff, tmp_in;
   logic [DW-1:0] coef_ff, coef_in;
   logic          sub_ff, sub_in;

   fsl_pkg::alu_cmd_type alu_cmd;
   logic [DW-1:0] alu_x, alu_y;
   logic          alu_done;
   logic [DW-1:0] alu_result;
   logic [W-1:0]  alu_rem;
   logic          op_state;

   logic [DW-1:0] n64, m64;
   logic [DW-1:0] lift;
   logic [W-1:0]  red;
   logic [DW-1:0] acc_upd;

   assign n64 = {{(DW-W){1'b0}}, n_ff};
   assign m64 = {{(DW-W){1'b0}}, m_ff};

   // negative operand lift: red = v mod m into [0,m), lift = m's added
   assign red     = (alu_rem == '0) ? '0 : (m_ff - alu_rem);
   assign lift    = alu_result + DW'(alu_rem != '0);
   assign acc_upd = sub_ff ? (acc_ff - alu_result) : (acc_ff + alu_result);

   // operand select for the shared unit
   always_comb begin
      op_state       = 1'b1;
      alu_cmd.is_div = 1'b0;
      alu_x          = '0;
      alu_y          = '0;
      unique case (state_ff)
         ST_A_DIV: begin
            alu_cmd.is_div = 1'b1;
            alu_x          = a_ff[DW-1] ? (DW'(0) - a_ff) : a_ff;
            alu_y          = m64;
         end
         ST_A_TRI: begin
            alu_x = n64;
            alu_y = n64 - DW'(1);
         end
         ST_A_SCALE: begin
            alu_x = {1'b0, tmp_ff[DW-1:1]};
            alu_y = coef_ff;
         end
         ST_B_DIV: begin
            alu_cmd.is_div = 1'b1;
            alu_x          = b_ff[DW-1] ? (DW'(0) - b_ff) : b_ff;
            alu_y          = m64;
         end
         ST_B_SCALE: begin
            alu_x = n64;
            alu_y = coef_ff;
         end
         ST_TOP_MUL: begin
            alu_x = a_ff;
            alu_y = n64;
         end
         ST_TOP_DIV: begin
            alu_cmd.is_div = 1'b1;
            alu_x          = tmp_ff;
            alu_y          = m64;
         end
         default: begin
            op_state = 1'b0;
         end
      endcase
      alu_cmd.start = op_state && !issued_ff;
   end

   fsl_alu #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_alu (
      .clock     (clock),
      .reset     (reset),
      .cmd       (alu_cmd),
      .opnd_x    (alu_x),
      .opnd_y    (alu_y),
      .done      (alu_done),
      .result    (alu_result),
      .remainder (alu_rem)
   );

   assign req_ready = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      total_in     = total_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      coef_in      = coef_ff;
      sub_in       = sub_ff;

      if (alu_cmd.start) begin
         issued_in = 1'b1;
      end else if (alu_done) begin
         issued_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in     = req_term_count[W-1:0];
               m_in     = req_modulus[W-1:0];
               a_in     = req_slope;
               b_in     = req_offset;
               acc_in   = '0;
               state_in = (req_modulus[W-1:0] == '0) ? ST_FINISH : ST_A_CHECK;
            end
         end
         ST_A_CHECK: begin
            state_in = (a_ff[DW-1] || (a_ff >= m64)) ? ST_A_DIV : ST_B_CHECK;
         end
         ST_A_DIV: begin
            if (alu_done) begin
               a_in     = a_ff[DW-1] ? DW'(red) : DW'(alu_rem);
               coef_in  = a_ff[DW-1] ? lift : alu_result;
               sub_in   = a_ff[DW-1];
               state_in = ST_A_TRI;
            end
         end
         ST_A_TRI: begin
            if (alu_done) begin
               tmp_in   = alu_result;
               state_in = ST_A_SCALE;
            end
         end
         ST_A_SCALE: begin
            if (alu_done) begin
               acc_in   = acc_upd;
               state_in = ST_B_CHECK;
            end
         end
         ST_B_CHECK: begin
            state_in = (b_ff[DW-1] || (b_ff >= m64)) ? ST_B_DIV : ST_TOP_MUL;
         end
         ST_B_DIV: begin
            if (alu_done) begin
               b_in     = b_ff[DW-1] ? DW'(red) : DW'(alu_rem);
               coef_in  = b_ff[DW-1] ? lift : alu_result;
               sub_in   = b_ff[DW-1];
               state_in = ST_B_SCALE;
            end
         end
         ST_B_SCALE: begin
            if (alu_done) begin
               acc_in   = acc_upd;
               state_in = ST_TOP_MUL;
            end
         end
         ST_TOP_MUL: begin
            if (alu_done) begin
               tmp_in   = alu_result + b_ff;
               state_in = ST_TOP_CHECK;
            end
         end
         ST_TOP_CHECK: begin
            state_in = (tmp_ff < m64) ? ST_FINISH : ST_TOP_DIV;
         end
         ST_TOP_DIV: begin
            // new count and offset, then swap modulus and slope
            if (alu_done) begin
               n_in     = alu_result[W-1:0];
               b_in     = DW'(alu_rem);
               m_in     = a_ff[W-1:0];
               a_in     = m64;
               state_in = ST_A_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               total_in     = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      total_ff <= total_in;
      n_ff     <= n_in;
      m_ff     <= m_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      tmp_ff   <= tmp_in;
      coef_ff  <= coef_in;
      sub_ff   <= sub_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_floor_total = total_ff;

endmodule

FILE: tb/floor_sum_linear_top_tb.sv
// ----------------------------------------------------------------------------
// floor_sum_linear_top_tb
// Self-checking bench for the floor-sum block. Every accepted request is run
// through a software copy of the Euclid-like reduction, and the predicted
// total is queued. Each returned total is checked against the oldest queued
// one. Stimulus is a directed set of corner cases followed by random
// requests under three idle mixes. One long response stall fills the block
// and backs up its input.
// ----------------------------------------------------------------------------
module floor_sum_linear_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPERAND_BITS   = fsl_pkg::OPERAND_BITS_DEF;
   localparam int DW             = fsl_pkg::DATA_BITS;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RSP_HOLD_LEN   = 4000;
   localparam int DRAIN_CYCLES   = 1000;
   localparam int PRESSURE_PHASE = 3;

   localparam logic [DW-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DW-1:0] MIN_NEG = 64'h8000_0000_0000_0000;

   typedef enum {TOTAL_OK, TOTAL_UNEXPECTED, TOTAL_WRONG} total_verdict_type;

   // Predicted totals, oldest first, with the arithmetic that makes them
   class floor_sum_board_type;
      bit [63:0] totals_due[$];
      bit [63:0] operand_mask;

      function new(int operand_bits);
         operand_mask = (64'd1 << operand_bits) - 64'd1;
      endfunction

      // n*(n-1)/2, zero for n = 0 through wrap
      function bit [63:0] tri_terms(bit [63:0] n);
         return (n * (n - 64'd1)) / 64'd2;
      endfunction

      // Lift a negative value into [0, m); lifts gets the number of m's added
      function bit [63:0] raise_negative(bit [63:0] v, bit [63:0] m,
                                         output bit [63:0] lifts);
         bit [63:0] mag;
         bit [63:0] rem;
         bit [63:0] red;
         mag   = 64'd0 - v;
         rem   = mag % m;
         red   = (rem == 64'd0) ? 64'd0 : (m - rem);
         lifts = (red + mag) / m;
         return red;
      endfunction

      // Euclid-like loop on non-negative slope and offset
      function bit [63:0] euclid_total(bit [63:0] n, bit [63:0] m,
                                       bit [63:0] a, bit [63:0] b);
         bit [63:0] acc;
         bit [63:0] top;
         bit [63:0] swap;
         bit        done;
         acc  = 64'd0;
         done = 1'b0;
         while (!done) begin
            if (a >= m) begin
               acc += tri_terms(n) * (a / m);
               a = a % m;
            end
            if (b >= m) begin
               acc += n * (b / m);
               b = b % m;
            end
            top = a * n + b;
            if (top < m) begin
               done = 1'b1;
            end else begin
               n    = top / m;
               b    = top % m;
               swap = m;
               m    = a;
               a    = swap;
            end
         end
         return acc;
      endfunction

      function bit [63:0] predict_total(logic [31:0] count, logic [31:0] modulus,
                                        logic [63:0] slope, logic [63:0] offset);
         bit [63:0] n;
         bit [63:0] m;
         bit [63:0] a;
         bit [63:0] b;
         bit [63:0] acc;
         bit [63:0] lifts;
         n = 64'(count) & operand_mask;
         m = 64'(modulus) & operand_mask;
         a = slope;
         b = offset;
         acc = 64'd0;
         if (m == 64'd0) begin
            return 64'd0;
         end
         if (a[63]) begin
            a = raise_negative(a, m, lifts);
            acc -= tri_terms(n) * lifts;
         end
         if (b[63]) begin
            b = raise_negative(b, m, lifts);
            acc -= n * lifts;
         end
         return acc + euclid_total(n, m, a, b);
      endfunction

      function void note_request(logic [31:0] count, logic [31:0] modulus,
                                 logic [63:0] slope, logic [63:0] offset);
         totals_due.push_back(predict_total(count, modulus, slope, offset));
      endfunction

      function total_verdict_type check_total(logic [63:0] got,
                                              output logic [63:0] want);
         if (totals_due.size() == 0) begin
            want = 64'd0;
            return TOTAL_UNEXPECTED;
         end
         want = totals_due.pop_front();
         return (got !== want) ? TOTAL_WRONG : TOTAL_OK;
      endfunction

      function int pending();
         return totals_due.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [31:0]          req_term_count = '0;
   logic [31:0]          req_modulus = '0;
   logic signed [DW-1:0] req_slope = '0;
   logic signed [DW-1:0] req_offset = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [DW-1:0] rsp_floor_total;

   floor_sum_board_type board = new(OPERAND_BITS);
   int error_count = 0;
   int idle_cycles = 0;
   int test_phase = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   always #2 clock = ~clock;

   floor_sum_linear_top #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_term_count (req_term_count),
      .req_modulus    (req_modulus),
      .req_slope      (req_slope),
      .req_offset     (req_offset),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_floor_total(rsp_floor_total)
   );

   task automatic report_mismatch(input string what);
      $display("%0t ns ERROR %s", $time, what);
      error_count++;
   endtask

   // Offer one request, with random idle cycles ahead of it; returns at the
   // edge that accepts it
   task automatic send_request(input logic [31:0] count, input logic [31:0] modulus,
                               input logic [63:0] slope, input logic [63:0] offset);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_term_count <= count;
      req_modulus    <= modulus;
      req_slope      <= slope;
      req_offset     <= offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(count, modulus, slope, offset);
   endtask

   // Random value of the given bit width, zero-extended
   function automatic logic [31:0] pick_bits(int bits);
      logic [63:0] mask;
      mask = (64'd1 << bits) - 64'd1;
      return 32'(64'($urandom) & mask);
   endfunction

   // Slope/offset mix: full random, small signed, near both extremes, 32-bit
   function automatic logic [63:0] pick_wide();
      unique case ($urandom_range(5))
         0, 5: return {$urandom, $urandom};
         1: return 64'(int'($urandom_range(40)) - 20);
         2: return MAX_POS - 64'($urandom_range(3));
         3: return MIN_NEG + 64'($urandom_range(3));
         default: return 64'(int'($urandom));
      endcase
   endfunction

   // Mostly narrow moduli keep the Euclid round count short
   task automatic send_random();
      logic [31:0] modulus;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 3) begin
         modulus = '0;
      end else if (pick < 70) begin
         modulus = pick_bits($urandom_range(1, 12));
      end else if (pick < 95) begin
         modulus = pick_bits($urandom_range(13, 20));
      end else begin
         modulus = pick_bits($urandom_range(21, 32));
      end
      send_request(pick_bits($urandom_range(0, 32)), modulus, pick_wide(), pick_wide());
   endtask

   // Response side: check, then choose ready; one long hold-off in the
   // pressure phase
   initial begin : rsp_sink
      logic [63:0]       want;
      total_verdict_type verdict;
      int                hold_left;
      bit                pressure_done;
      hold_left     = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            verdict = board.check_total(rsp_floor_total, want);
            if (verdict == TOTAL_UNEXPECTED) begin
               report_mismatch($sformatf("floor_total %h with no request outstanding",
                                         rsp_floor_total));
            end else if (verdict == TOTAL_WRONG) begin
               report_mismatch($sformatf("floor_total got %h want %h",
                                         rsp_floor_total, want));
            end
         end
         if (test_phase == PRESSURE_PHASE && !pressure_done) begin
            hold_left     = RSP_HOLD_LEN;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("floor_sum_linear_top_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender idles lightly, receiver heavily
      test_phase   = 1;
      req_idle_pct = 22;
      rsp_idle_pct = 50;

      // Corner cases: empty and single-term sums, zero modulus, wrap,
      // extreme and negative slope/offset, worst-case round count
      send_request(32'd0, 32'd1, 64'd0, 64'd0);
      send_request(32'd0, 32'hFFFF_FFFF, MAX_POS, MIN_NEG);
      send_request(32'd1, 32'd7, 64'd5, -64'sd20);
      send_request(32'd1, 32'hFFFF_FFFF, MIN_NEG, MIN_NEG);
      send_request(32'hFFFF_FFFF, 32'd1, MAX_POS, MAX_POS);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, MIN_NEG, MIN_NEG);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h9E37_79B9, 64'd0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, MAX_POS, MAX_POS);
      send_request(32'd10, 32'd3, -64'sd1, -64'sd1);
      send_request(32'd100, 32'd0, 64'd123, 64'd456);
      send_request(32'hFFFF_FFFF, 32'd0, MIN_NEG, MAX_POS);
      send_request(32'd1000, 32'd17, 64'd17, 64'd16);
      send_request(32'd1000, 32'd17, 64'd0, 64'd0);
      send_request(32'd5, 32'h8000_0000, 64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF);
      send_request(32'h5555_5555, 32'hAAAA_AAAB, 64'h5555_5555_5555_5555,
                   64'hAAAA_AAAA_AAAA_AAAA);
      send_request(32'hAAAA_AAAA, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                   64'h5555_5555_5555_5555);
      send_request(32'd2, 32'd1, -64'sd1, 64'd0);
      send_request(32'h0001_0000, 32'd12345, -64'sd98765, 64'sd4321);

      repeat (50) send_random();

      // Roles swapped
      test_phase   = 2;
      req_idle_pct = 50;
      rsp_idle_pct = 22;
      repeat (50) send_random();

      // No idling; receiver opens with a long stall
      test_phase   = PRESSURE_PHASE;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (50) send_random();
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("floor_sum_linear_top_tb: done, clean");
      end else begin
         $display("floor_sum_linear_top_tb: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/fsl_pkg.sv
design/fsl_alu.sv
design/floor_sum_linear_top.sv
tb/floor_sum_linear_top_tb.sv
